FILE: rtl/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also runs during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/sm4_pkg.sv
// Shared types, command codes and round function for the SM4 engine
`default_nettype none

package sm4_pkg;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ENCRYPT = 2'd1;
    localparam logic [1:0] CMD_DECRYPT = 2'd2;

    localparam int unsigned NUM_ROUNDS = 32;
    localparam int unsigned KEY_AW     = 5;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  key_index;
        logic [31:0] key_word;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_beat;

    typedef struct packed {
        logic              key_wr;
        logic              load_blk;
        logic              step;
        logic [KEY_AW-1:0] rd_addr;
    } t_dp_ctrl;

    localparam logic [7:0] SBOX [256] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    // S-box on each byte, then the linear transform L
    function automatic logic [31:0] t_func(input logic [31:0] a);
        logic [31:0] b;
        b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sm4_ctrl.sv
// Controller: command decode, round counter and result strobe
`default_nettype none

module sm4_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_command,
    output sm4_pkg::t_dp_ctrl      o_ctrl,
    output logic                   o_done
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                       r_state, n_state;
    logic [sm4_pkg::KEY_AW-1:0] r_round, n_round;
    logic                       r_dec,   n_dec;
    logic                       r_done,  n_done;
    logic [sm4_pkg::KEY_AW-1:0] w_next_round;
    logic                       w_accept;
    logic                       w_crypt;

    assign w_accept     = start && (r_state == ST_IDLE);
    assign w_crypt      = (i_command == sm4_pkg::CMD_ENCRYPT)
                       || (i_command == sm4_pkg::CMD_DECRYPT);
    assign w_next_round = r_round + 1'b1;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_dec   = r_dec;
        n_done  = 1'b0;
        o_ctrl.key_wr   = 1'b0;
        o_ctrl.load_blk = 1'b0;
        o_ctrl.step     = 1'b0;
        o_ctrl.rd_addr  = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_command == sm4_pkg::CMD_LOAD)) begin
                    o_ctrl.key_wr = 1'b1;
                end
                if (w_accept && w_crypt) begin
                    o_ctrl.load_blk = 1'b1;
                    n_dec   = (i_command == sm4_pkg::CMD_DECRYPT);
                    n_round = '0;
                    n_state = ST_RUN;
                    // fetch the first round key: slot 0 forward, last slot backward
                    o_ctrl.rd_addr = (i_command == sm4_pkg::CMD_DECRYPT) ? '1 : '0;
                end
            end
            ST_RUN: begin
                o_ctrl.step    = 1'b1;
                o_ctrl.rd_addr = r_dec ? ~w_next_round : w_next_round;
                n_round        = w_next_round;
                if (r_round == sm4_pkg::KEY_AW'(sm4_pkg::NUM_ROUNDS - 1)) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
            r_dec   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_dec   <= n_dec;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state == ST_RUN);
    assign o_done = r_done;

endmodule

`default_nettype wire

FILE: rtl/sm4_dp.sv
// Datapath: round-key memory, block word registers and the round function
`default_nettype none

module sm4_dp (
    input  wire logic                i_clk,
    input  wire sm4_pkg::t_in_beat   i_in,
    input  wire sm4_pkg::t_dp_ctrl   i_ctrl,
    output sm4_pkg::t_out_beat       o_result
);

    logic [31:0] r_keys [sm4_pkg::NUM_ROUNDS];
    logic [31:0] r_key;
    logic [31:0] r_x0, r_x1, r_x2, r_x3;
    logic [31:0] w_new;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.key_wr) begin
            r_keys[i_in.key_index] <= i_in.key_word;
        end
        r_key <= r_keys[i_ctrl.rd_addr];
    end

    assign w_new = r_x0 ^ sm4_pkg::t_func(r_x1 ^ r_x2 ^ r_x3 ^ r_key);

    // load the block words on a block command, then advance the word window by one each round
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_blk) begin
            r_x0 <= i_in.block_high[63:32];
            r_x1 <= i_in.block_high[31:0];
            r_x2 <= i_in.block_low[63:32];
            r_x3 <= i_in.block_low[31:0];
        end else if (i_ctrl.step) begin
            r_x0 <= r_x1;
            r_x1 <= r_x2;
            r_x2 <= r_x3;
            r_x3 <= w_new;
        end
    end

    assign o_result.result_high = {r_x3, r_x2};
    assign o_result.result_low  = {r_x1, r_x0};

endmodule

`default_nettype wire

FILE: rtl/sm4_block_cipher_top.sv
// Top level of the SM4 block cipher engine
//
//   channel   signals                      accepted when
//   command   start, busy, i_in            start high and busy low at the clock edge
//   result    o_done, o_result             o_done high, one cycle, no back-pressure
//
// A load command writes the round-key memory.
// An encrypt or decrypt runs 32 rounds, one per cycle, each paced by one read of the
// round-key memory, then raises the result strobe.
// busy is high during the rounds; a new command may start in the strobe cycle.
// Synchronous reset clears the controller; round keys keep their contents.
`default_nettype none

module sm4_block_cipher_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire sm4_pkg::t_in_beat   i_in,
    output logic                     o_done,
    output sm4_pkg::t_out_beat       o_result
);

    sm4_pkg::t_dp_ctrl w_ctrl;

    sm4_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_command (i_in.command),
        .o_ctrl    (w_ctrl),
        .o_done    (o_done)
    );

    sm4_dp u_dp (
        .i_clk    (i_clk),
        .i_in     (i_in),
        .i_ctrl   (w_ctrl),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

FILE: rtl/sm4_checker.sv
// Port-level checks on the SM4 engine, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module sm4_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire sm4_pkg::t_in_beat i_in,
    input wire logic              o_done
);

    `ASSERT_CLK(a_busy_from_crypt, $rose(busy) && $past(i_rst_n) |-> $past(start) && ($past(i_in.command) == sm4_pkg::CMD_ENCRYPT || $past(i_in.command) == sm4_pkg::CMD_DECRYPT), "busy rose without an encrypt or decrypt beat")
    `ASSERT_CLK(a_done_on_finish, $fell(busy) && $past(i_rst_n) |-> o_done, "rounds ended without a result strobe")
    `ASSERT_CLK(a_done_single, o_done |=> !o_done, "result strobe lasted more than one cycle")
    `ASSERT_CLK(a_done_idle, o_done |-> !busy, "result strobe while rounds still run")

endmodule

bind sm4_block_cipher_top sm4_checker u_chk (.*);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the SM4 block cipher engine top level
`timescale 1ns / 100ps

module tb;

    localparam int RAND_ITEMS  = 680;
    localparam int DRAIN_TICKS = 80;

    localparam bit [7:0] SUBST [256] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,
        8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,
        8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,
        8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,
        8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,
        8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,
        8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,
        8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,
        8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,
        8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,
        8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,
        8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,
        8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,
        8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,
        8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,
        8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,
        8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    sm4_pkg::t_in_beat    i_in    = '0;
    logic                 busy;
    logic                 o_done;
    sm4_pkg::t_out_beat   o_result;

    bit [31:0]            key_store [32];
    sm4_pkg::t_in_beat    pending_cmds [$];
    sm4_pkg::t_out_beat   expected_blocks [$];
    int                   total_items = 0;
    int                   n_taken     = 0;
    int                   rst_ticks   = 0;
    int                   err_count   = 0;

    sm4_block_cipher_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        rst_ticks <= rst_ticks + 1;
        if (rst_ticks == 10) begin
            i_rst_n <= 1'b1;
        end
    end

    function automatic bit [31:0] rol32(bit [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // byte substitution followed by the linear mix
    function automatic bit [31:0] round_mix(bit [31:0] a);
        bit [31:0] b;
        b = {SUBST[a[31:24]], SUBST[a[23:16]], SUBST[a[15:8]], SUBST[a[7:0]]};
        return b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
    endfunction

    function automatic sm4_pkg::t_out_beat cipher_block(sm4_pkg::t_in_beat beat);
        bit [31:0]          x [4];
        int                 k;
        sm4_pkg::t_out_beat res;
        x[0] = beat.block_high[63:32];
        x[1] = beat.block_high[31:0];
        x[2] = beat.block_low[63:32];
        x[3] = beat.block_low[31:0];
        for (int i = 0; i < 32; i++) begin
            k = (beat.command == sm4_pkg::CMD_DECRYPT) ? 31 - i : i;
            x[i % 4] ^= round_mix(x[(i + 1) % 4] ^ x[(i + 2) % 4] ^ x[(i + 3) % 4]
                                  ^ key_store[k]);
        end
        res.result_high = {x[3], x[2]};
        res.result_low  = {x[1], x[0]};
        return res;
    endfunction

    task automatic queue_cmd(logic [1:0] cmd, logic [4:0] idx, logic [31:0] word,
                             logic [63:0] hi, logic [63:0] lo);
        sm4_pkg::t_in_beat beat;
        beat.command    = cmd;
        beat.key_index  = idx;
        beat.key_word   = word;
        beat.block_high = hi;
        beat.block_low  = lo;
        pending_cmds.push_back(beat);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // driver: predict on each accepted beat, then present the next one
    always @(posedge i_clk) begin
        int  idle_pct;
        bit  taken;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                case (i_in.command)
                    sm4_pkg::CMD_LOAD: begin
                        key_store[i_in.key_index] = i_in.key_word;
                    end
                    sm4_pkg::CMD_ENCRYPT, sm4_pkg::CMD_DECRYPT: begin
                        expected_blocks.push_back(cipher_block(i_in));
                    end
                    default: begin
                    end
                endcase
            end
            if (!start || taken) begin
                if (n_taken * 3 < total_items) begin
                    idle_pct = 13;
                end else if (n_taken * 3 < total_items * 2) begin
                    idle_pct = 55;
                end else begin
                    idle_pct = 0;
                end
                if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_in  <= pending_cmds.pop_front();
                    start <= 1'b1;
                    n_taken++;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe must match the oldest expected block
    always @(posedge i_clk) begin
        sm4_pkg::t_out_beat want;
        if (i_rst_n && o_done) begin
            if (expected_blocks.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected result beat: high %h low %h",
                             o_result.result_high, o_result.result_low);
                end
            end else begin
                want = expected_blocks.pop_front();
                if (o_result.result_high !== want.result_high) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("result_high mismatch: expected %h actual %h",
                                 want.result_high, o_result.result_high);
                    end
                end
                if (o_result.result_low !== want.result_low) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("result_low mismatch: expected %h actual %h",
                                 want.result_low, o_result.result_low);
                    end
                end
            end
        end
    end

    initial begin
        int n_rand;
        int pick;
        logic [63:0] hi;
        logic [63:0] lo;

        // fill every key slot before any block reads it
        for (int i = 0; i < 32; i++) begin
            queue_cmd(sm4_pkg::CMD_LOAD, i[4:0],
                      (i == 0) ? 32'h0 : (i == 31) ? 32'hFFFF_FFFF : $urandom,
                      rand64(), rand64());
        end
        queue_cmd(sm4_pkg::CMD_ENCRYPT, 5'h1F, 32'hFFFF_FFFF, 64'h0, 64'h0);
        queue_cmd(sm4_pkg::CMD_ENCRYPT, 5'h00, 32'h0, '1, '1);
        queue_cmd(sm4_pkg::CMD_DECRYPT, 5'h1F, 32'hFFFF_FFFF, 64'h0, 64'h0);
        queue_cmd(sm4_pkg::CMD_DECRYPT, 5'h00, 32'h0, '1, '1);
        queue_cmd(sm4_pkg::CMD_ENCRYPT, 5'($urandom), $urandom,
                  {4{16'h5555}}, {4{16'hAAAA}});
        queue_cmd(sm4_pkg::CMD_DECRYPT, 5'($urandom), $urandom,
                  {4{16'hAAAA}}, {4{16'h5555}});
        // unused code with every field at its top value, then at zero: must be ignored
        queue_cmd(CMD_UNUSED, 5'h1F, 32'hFFFF_FFFF, '1, '1);
        queue_cmd(CMD_UNUSED, 5'h00, 32'h0, 64'h0, 64'h0);
        // load directly followed by a block that uses the new key
        queue_cmd(sm4_pkg::CMD_LOAD, 5'd7, 32'h0, '1, '1);
        queue_cmd(sm4_pkg::CMD_ENCRYPT, 5'($urandom), $urandom, rand64(), rand64());
        queue_cmd(sm4_pkg::CMD_LOAD, 5'd7, 32'hFFFF_FFFF, 64'h0, 64'h0);
        queue_cmd(sm4_pkg::CMD_DECRYPT, 5'($urandom), $urandom, rand64(), rand64());
        queue_cmd(sm4_pkg::CMD_ENCRYPT, 5'($urandom), $urandom, rand64(), rand64());
        queue_cmd(sm4_pkg::CMD_DECRYPT, 5'($urandom), $urandom, rand64(), rand64());

        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            pick = $urandom_range(99);
            hi = rand64();
            lo = rand64();
            if ($urandom_range(19) == 0) begin
                hi = $urandom_range(1) ? '1 : 64'h0;
                lo = $urandom_range(1) ? '1 : 64'h0;
            end
            if (pick < 8) begin
                queue_cmd(sm4_pkg::CMD_LOAD, 5'($urandom), $urandom, hi, lo);
                n_rand++;
            end else if (pick < 12) begin
                queue_cmd(CMD_UNUSED, 5'($urandom), $urandom, hi, lo);
            end else begin
                queue_cmd($urandom_range(1) ? sm4_pkg::CMD_ENCRYPT : sm4_pkg::CMD_DECRYPT,
                          5'($urandom), $urandom, hi, lo);
                n_rand++;
            end
        end
        total_items = pending_cmds.size();

        // hold until every beat is taken and every result is back
        while (pending_cmds.size() != 0 || start) begin
            @(posedge i_clk);
        end
        while (expected_blocks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_TICKS) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sm4_block_cipher_top.f
+incdir+rtl
rtl/sm4_pkg.sv
rtl/sm4_ctrl.sv
rtl/sm4_dp.sv
rtl/sm4_block_cipher_top.sv
rtl/sm4_checker.sv
tb/tb.sv
